### hw/rtl/wssd_pkg.sv
// Shared widths, reciprocal constants and calendar tables for the week-start date core.
// No dependencies; used by week_start_sunday_date_core and wssd_checker.
`default_nettype none

package wssd_pkg;

	localparam int unsigned CodeW  = 27;
	localparam int unsigned YearW  = 14;
	localparam int unsigned RemW   = 14;
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned WdW    = 3;

	// Pipeline depth from transfer in to result strobe
	localparam int unsigned Latency = 7;

	// code / 10000 = (code >> 4) / 625 = ((code >> 4) * Rcp625) >> 33
	localparam logic [23:0] Rcp625   = 24'd13743896;
	localparam int unsigned Sh625    = 33;
	// x / 100 for x < 10000
	localparam logic [12:0] Rcp100r  = 13'd5243;
	localparam int unsigned Sh100r   = 19;
	// year / 100 for 14-bit year
	localparam logic [13:0] Rcp100y  = 14'd10486;
	localparam int unsigned Sh100y   = 20;
	// x / 7 for x < 2048
	localparam logic [13:0] Rcp7     = 14'd9363;
	localparam int unsigned Sh7      = 16;

	localparam logic [MonthW-1:0] MonJan = 4'd1;
	localparam logic [MonthW-1:0] MonFeb = 4'd2;
	localparam logic [MonthW-1:0] MonDec = 4'd12;

	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] d;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
				4'd2:                                       d = leap ? 5'd29 : 5'd28;
				default:                                    d = 5'd0;
			endcase
			return d;
		end
	endfunction

	// (13 * (m' + 1) / 5) mod 7, with January and February taken as months 13 and 14
	function automatic logic [WdW-1:0] zeller_month(input logic [MonthW-1:0] m);
		logic [WdW-1:0] t;
		begin
			case (m)
				4'd1:    t = 3'd1;
				4'd2:    t = 3'd4;
				4'd3:    t = 3'd3;
				4'd4:    t = 3'd6;
				4'd5:    t = 3'd1;
				4'd6:    t = 3'd4;
				4'd7:    t = 3'd6;
				4'd8:    t = 3'd2;
				4'd9:    t = 3'd5;
				4'd10:   t = 3'd0;
				4'd11:   t = 3'd3;
				4'd12:   t = 3'd5;
				default: t = 3'd0;
			endcase
			return t;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/week_start_sunday_date_core.sv
// Week-start (Sunday) date core: YYYYMMDD in, Sunday of that week and weekday out.
// Seven-stage pipeline; depends on wssd_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  input    | start & !busy            | date_code
//  result   | done (one-cycle strobe)  | week_start_code, day_of_week, date_ok
//
// One date can enter per cycle while busy is low; results leave in transfer order.
// Each stage ends in a register: year, MMDD remainder, month and century, day,
// Zeller sum, mod 7, repack; year, month, century and mod 7 use reciprocals.
// busy is high only while in reset and the cycle after; no state is kept across dates.
// The receiver cannot stall: the pipeline advances every cycle.
`default_nettype none

module week_start_sunday_date_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [wssd_pkg::CodeW-1:0]     date_code,
	output logic                                done,
	output logic      [wssd_pkg::CodeW-1:0]     week_start_code,
	output logic      [wssd_pkg::WdW-1:0]       day_of_week,
	output logic                                date_ok
);

	logic ready_q;
	logic [wssd_pkg::Latency-1:0] vld;

	// stage 1
	logic [46:0]                     yprod0;
	logic [wssd_pkg::CodeW-1:0]      code_s1;
	logic [wssd_pkg::YearW-1:0]      year_s1;
	// stage 2
	logic [wssd_pkg::CodeW-1:0]      ypack;
	logic [wssd_pkg::YearW-1:0]      year_s2;
	logic [wssd_pkg::RemW-1:0]       rem_s2;
	// stage 3
	logic [26:0]                     mprod;
	logic [27:0]                     cprod;
	logic [wssd_pkg::YearW-1:0]      year_s3;
	logic [wssd_pkg::RemW-1:0]       rem_s3;
	logic [6:0]                      month_s3;
	logic [7:0]                      yc_s3;
	logic                            adj_s3;
	// stage 4
	logic [wssd_pkg::RemW-1:0]       dayw;
	logic [wssd_pkg::YearW-1:0]      yr100w;
	logic [6:0]                      yr100;
	logic [wssd_pkg::YearW-1:0]      year_s4;
	logic [6:0]                      month_s4;
	logic [6:0]                      day_s4;
	logic [6:0]                      k_s4;
	logic [7:0]                      j_s4;
	logic                            leap_s4;
	// stage 5
	logic [wssd_pkg::MonthW-1:0]     mon4;
	logic [wssd_pkg::DayW-1:0]       dim;
	logic [wssd_pkg::MonthW-1:0]     pmon;
	logic                            mok;
	logic [wssd_pkg::YearW-1:0]      year_s5;
	logic [wssd_pkg::MonthW-1:0]     month_s5;
	logic [wssd_pkg::DayW-1:0]       day_s5;
	logic [wssd_pkg::DayW-1:0]       pdim_s5;
	logic [10:0]                     sum_s5;
	logic                            ok_s5;
	// stage 6
	logic [24:0]                     qprod;
	logic [10:0]                     h7;
	logic [wssd_pkg::WdW-1:0]        h;
	logic [wssd_pkg::WdW-1:0]        wd;
	logic [wssd_pkg::YearW-1:0]      year_s6;
	logic [wssd_pkg::MonthW-1:0]     month_s6;
	logic [wssd_pkg::DayW-1:0]       day_s6;
	logic [wssd_pkg::WdW-1:0]        wd_s6;
	logic                            ok_s6;
	// stage 7
	logic [wssd_pkg::CodeW-1:0]      pack;

	assign busy = !ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			vld     <= '0;
		end else begin
			ready_q <= 1'b1;
			vld     <= {vld[wssd_pkg::Latency-2:0], start & ready_q};
		end
	end

	assign done = vld[wssd_pkg::Latency-1];

	// s1: year by reciprocal of 10000
	assign yprod0 = 47'(date_code[wssd_pkg::CodeW-1:4]) * 47'(wssd_pkg::Rcp625);

	// s2: remainder MMDD
	assign ypack = wssd_pkg::CodeW'(year_s1) * wssd_pkg::CodeW'(14'd10000);

	// s3: month and century by reciprocal of 100
	assign mprod = 27'(rem_s2) * 27'(wssd_pkg::Rcp100r);
	assign cprod = 28'(year_s2) * 28'(wssd_pkg::Rcp100y);

	// s4: day, year within century, Zeller k and j
	assign dayw   = rem_s3 - wssd_pkg::RemW'(month_s3) * 14'd100;
	assign yr100w = year_s3 - wssd_pkg::YearW'(yc_s3) * 14'd100;
	assign yr100  = yr100w[6:0];

	// s5: validity, month lengths, Zeller sum
	assign mon4 = month_s4[3:0];
	assign mok  = (month_s4 >= 7'd1) && (month_s4 <= 7'd12);
	assign dim  = wssd_pkg::month_days(mon4, leap_s4);
	assign pmon = (mon4 == wssd_pkg::MonJan) ? wssd_pkg::MonDec : mon4 - 4'd1;

	// s6: mod 7, weekday, step back to Sunday
	assign qprod = 25'(sum_s5) * 25'(wssd_pkg::Rcp7);
	assign h7    = sum_s5 - 11'(qprod[24:wssd_pkg::Sh7]) * 11'd7;
	assign h     = h7[2:0];
	assign wd    = (h == 3'd0) ? 3'd6 : h - 3'd1;

	// s7: repack
	assign pack = wssd_pkg::CodeW'(year_s6) * wssd_pkg::CodeW'(14'd10000)
		+ wssd_pkg::CodeW'(month_s6) * wssd_pkg::CodeW'(7'd100)
		+ wssd_pkg::CodeW'(day_s6);

	always_ff @(posedge clk) begin
		code_s1 <= date_code;
		year_s1 <= yprod0[wssd_pkg::Sh625 +: wssd_pkg::YearW];

		year_s2 <= year_s1;
		rem_s2  <= wssd_pkg::RemW'(code_s1 - ypack);

		year_s3  <= year_s2;
		rem_s3   <= rem_s2;
		month_s3 <= mprod[wssd_pkg::Sh100r +: 7];
		yc_s3    <= cprod[wssd_pkg::Sh100y +: 8];
		adj_s3   <= rem_s2 < 14'd300;

		year_s4  <= year_s3;
		month_s4 <= month_s3;
		day_s4   <= dayw[6:0];
		// Jan/Feb count as months of the previous year
		k_s4     <= !adj_s3 ? yr100 : ((yr100 == 7'd0) ? 7'd99 : yr100 - 7'd1);
		j_s4     <= (adj_s3 && (yr100 == 7'd0)) ? yc_s3 - 8'd1 : yc_s3;
		leap_s4  <= (year_s3[1:0] == 2'b00) && ((yr100 != 7'd0) || (yc_s3[1:0] == 2'b00));

		year_s5  <= year_s4;
		month_s5 <= mon4;
		day_s5   <= day_s4[4:0];
		pdim_s5  <= wssd_pkg::month_days(pmon, leap_s4);
		ok_s5    <= (year_s4 != '0) && mok && (day_s4 != 7'd0) && (day_s4 <= 7'(dim));
		sum_s5   <= 11'(day_s4) + 11'(wssd_pkg::zeller_month(mon4)) + 11'(k_s4)
			+ 11'(k_s4[6:2]) + 11'(j_s4[7:2]) + 11'(j_s4) * 11'd5;

		ok_s6 <= ok_s5;
		wd_s6 <= wd;
		if (day_s5 > 5'(wd)) begin
			year_s6  <= year_s5;
			month_s6 <= month_s5;
			day_s6   <= day_s5 - 5'(wd);
		end else begin
			year_s6  <= (month_s5 == wssd_pkg::MonJan) ? year_s5 - 14'd1 : year_s5;
			month_s6 <= (month_s5 == wssd_pkg::MonJan) ? wssd_pkg::MonDec : month_s5 - 4'd1;
			day_s6   <= day_s5 + pdim_s5 - 5'(wd);
		end

		week_start_code <= ok_s6 ? pack : '0;
		day_of_week     <= ok_s6 ? wd_s6 : '0;
		date_ok         <= ok_s6;
	end

endmodule

`default_nettype wire

### hw/rtl/wssd_checker.sv
// Port-level checker for week_start_sunday_date_core, with its bind.
// Depends on wssd_pkg.
`default_nettype none

module wssd_props (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic [wssd_pkg::CodeW-1:0]  date_code,
	input wire logic                        done,
	input wire logic [wssd_pkg::CodeW-1:0]  week_start_code,
	input wire logic [wssd_pkg::WdW-1:0]    day_of_week,
	input wire logic                        date_ok
);

	// every transfer is followed by its result strobe once it has passed through the pipeline
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(wssd_pkg::Latency) done)
		else $error("no result strobe seven cycles after a transfer");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, wssd_pkg::Latency))
		else $error("result strobe without a transfer seven cycles earlier");

	a_wd_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (day_of_week <= 3'd6))
		else $error("weekday out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !date_ok) |-> (week_start_code == '0 && day_of_week == '0))
		else $error("invalid date with non-zero result");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && date_ok) |-> (week_start_code != '0))
		else $error("valid date with zero week start");

endmodule

bind week_start_sunday_date_core wssd_props u_wssd_props (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.date_code       (date_code),
	.done            (done),
	.week_start_code (week_start_code),
	.day_of_week     (day_of_week),
	.date_ok         (date_ok)
);

`default_nettype wire

### bench/wssd_checker.sv
// Checker for the week-start date core: predicts the Sunday, weekday and validity flag
// for every date transfer and compares each result strobe against the oldest prediction.
// Depends on wssd_pkg for widths.
`default_nettype none

module wssd_checker
	import wssd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [CodeW-1:0]  date_code,
	input  wire logic              done,
	input  wire logic [CodeW-1:0]  week_start_code,
	input  wire logic [WdW-1:0]    day_of_week,
	input  wire logic              date_ok,
	output int                     mismatch_count,
	output int                     outstanding,
	output int                     results_seen,
	output int                     valid_seen
);

	typedef struct {
		logic [CodeW-1:0] sunday;
		logic [WdW-1:0]   weekday;
		logic             ok;
	} week_t;

	week_t sunday_q[$];
	week_t oldest;

	function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
		logic leap;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		case (mo)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic week_t predict_sunday(input logic [CodeW-1:0] code);
		week_t       r;
		int unsigned yr, mo, dy, zy, zm, k, j, h, wd;
		r.sunday  = '0;
		r.weekday = '0;
		r.ok      = 1'b0;
		yr = code / 10000;
		mo = (code / 100) % 100;
		dy = code % 100;
		if (yr == 0 || mo < 1 || mo > 12 || dy < 1 || dy > month_length(mo, yr))
			return r;
		// Zeller: January and February count as months 13 and 14 of the year before
		zy = yr;
		zm = mo;
		if (mo < 3) begin
			zm = mo + 12;
			zy = yr - 1;
		end
		k  = zy % 100;
		j  = zy / 100;
		h  = (dy + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
		wd = (h + 6) % 7;
		if (dy > wd) begin
			dy = dy - wd;
		end else begin
			// borrow a month; early January of year 1 lands in year 0
			if (mo == 1) begin
				mo = 12;
				yr = yr - 1;
			end else begin
				mo = mo - 1;
			end
			dy = dy + month_length(mo, yr) - wd;
		end
		r.sunday  = CodeW'(yr * 10000 + mo * 100 + dy);
		r.weekday = WdW'(wd);
		r.ok      = 1'b1;
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			mismatch_count = 0;
			outstanding    = 0;
			results_seen   = 0;
			valid_seen     = 0;
			sunday_q.delete();
		end else begin
			if (done) begin
				if (sunday_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result: week_start_code %0d day_of_week %0d date_ok %0b",
						$time, week_start_code, day_of_week, date_ok);
				end else begin
					oldest = sunday_q.pop_front();
					outstanding--;
					results_seen++;
					if (date_ok)
						valid_seen++;
					if (week_start_code !== oldest.sunday) begin
						mismatch_count++;
						$display("%0t: week_start_code expected %0d actual %0d",
							$time, oldest.sunday, week_start_code);
					end
					if (day_of_week !== oldest.weekday) begin
						mismatch_count++;
						$display("%0t: day_of_week expected %0d actual %0d",
							$time, oldest.weekday, day_of_week);
					end
					if (date_ok !== oldest.ok) begin
						mismatch_count++;
						$display("%0t: date_ok expected %0b actual %0b",
							$time, oldest.ok, date_ok);
					end
				end
			end
			if (start && !busy) begin
				sunday_q.push_back(predict_sunday(date_code));
				outstanding++;
			end
		end
	end

endmodule

`default_nettype wire

### bench/week_start_sunday_date_core_test.sv
// Top of the week-start date core bench: clock, reset, directed and random date stimulus.
// Instantiates week_start_sunday_date_core and wssd_checker; depends on wssd_pkg.
`default_nettype none

module week_start_sunday_date_core_test;
	import wssd_pkg::*;

	localparam int RandomDates = 1425;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CodeW-1:0] date_code;
	logic             done;
	logic [CodeW-1:0] week_start_code;
	logic [WdW-1:0]   day_of_week;
	logic             date_ok;

	int mismatch_count, outstanding, results_seen, valid_seen;
	int dates_sent;
	int burst_left;
	int settle;

	logic [CodeW-1:0] corner_dates[$];

	week_start_sunday_date_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.date_code       (date_code),
		.done            (done),
		.week_start_code (week_start_code),
		.day_of_week     (day_of_week),
		.date_ok         (date_ok)
	);

	wssd_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.date_code       (date_code),
		.done            (done),
		.week_start_code (week_start_code),
		.day_of_week     (day_of_week),
		.date_ok         (date_ok),
		.mismatch_count  (mismatch_count),
		.outstanding     (outstanding),
		.results_seen    (results_seen),
		.valid_seen      (valid_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Idle gap before the next transfer; bursts of back-to-back dates now and then
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 16);
	endfunction

	// Mostly well-formed dates with early-month days weighted up, plus raw codes
	function automatic logic [CodeW-1:0] random_date();
		int unsigned pick, yr, mo, dy;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return CodeW'($urandom);
		if (pick < 22)
			return CodeW'($urandom_range(0, 99991231));
		case ($urandom_range(0, 19))
			0:       yr = $urandom_range(0, 1);
			1:       yr = $urandom_range(10000, 13421);
			2:       yr = 100 * $urandom_range(1, 99);
			default: yr = $urandom_range(1, 9999);
		endcase
		if ($urandom_range(0, 19) == 0)
			mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
		else
			mo = $urandom_range(1, 12);
		pick = $urandom_range(0, 99);
		if (pick < 3)
			dy = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
		else if (pick < 33)
			dy = $urandom_range(1, 7);
		else if (pick < 85)
			dy = $urandom_range(8, 28);
		else
			dy = $urandom_range(29, 31);
		return CodeW'(yr * 10000 + mo * 100 + dy);
	endfunction

	task automatic send_date(input logic [CodeW-1:0] code);
		int gap;
		gap = next_gap();
		repeat (gap) begin
			@(negedge clk);
			start     <= 1'b0;
			date_code <= CodeW'($urandom);
		end
		@(negedge clk);
		start     <= 1'b1;
		date_code <= code;
		do @(posedge clk); while (busy);
		dates_sent++;
	endtask

	// Drop start and hold off until every outstanding result has arrived or the settle limit is reached
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		settle = 0;
		while (outstanding != 0 && settle < 500) begin
			@(negedge clk);
			settle++;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		date_code  = '0;
		dates_sent = 0;
		burst_left = 0;
		corner_dates = '{
			27'd0, 27'd99991231, 27'h7FFFFFF, 27'd67108864, 27'd1231,
			27'd10101, 27'd10102, 27'd10105, 27'd10106, 27'd10107,
			27'd20000229, 27'd19000229, 27'd19000228, 27'd20240229, 27'd20230229,
			27'd20241301, 27'd20240001, 27'd20240100, 27'd20240431, 27'd20240430,
			27'd20240301, 27'd20230301, 27'd20250101, 27'd134211231, 27'd99990101
		};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (corner_dates[i])
			send_date(corner_dates[i]);
		drain_results();

		for (int n = 0; n < RandomDates; n++) begin
			send_date(random_date());
			if (n % 350 == 349)
				drain_results();
		end
		drain_results();
		repeat (Latency + 3) @(posedge clk);

		$display("Sent %0d dates (%0d corner cases, rest random with idle gaps and bursts)",
			dates_sent, corner_dates.size());
		$display("Checked %0d results: %0d valid dates, %0d rejected",
			results_seen, valid_seen, results_seen - valid_seen);
		if (mismatch_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

### week_start_sunday_date_core.f
hw/rtl/wssd_pkg.sv
hw/rtl/week_start_sunday_date_core.sv
hw/rtl/wssd_checker.sv
bench/wssd_checker.sv
bench/week_start_sunday_date_core_test.sv
